// ----- hw/rtl/hrrn_pkg.sv -----
package hrrn_pkg;

	// Table size and derived widths
	localparam int MAX_PROCESSES = 32;
	localparam int SLOT_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

	// Field widths
	localparam int ARR_W = 16;
	localparam int RUN_W = 16;
	localparam int TIME_W = 32;
	localparam int IDX_W = 5;
	localparam int STATUS_W = 3;
	localparam int MEM_W = ARR_W + RUN_W;

	// Response ratio numerator: (now - arrival) + run, one bit of headroom
	localparam int NUM_W = TIME_W + 1;
	localparam int PROD_W = NUM_W + RUN_W;

	// Commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_LOADED = 3'd0,
		STAT_DISPATCHED = 3'd1,
		STAT_EMPTY = 3'd2,
		STAT_FULL = 3'd3,
		STAT_ZERO_RUN = 3'd4
	} status_t;

endpackage

// ----- hw/rtl/hrrn_item_if.sv -----
interface hrrn_item_if;
	import hrrn_pkg::*;

	logic valid;
	logic ready;
	logic cmd;
	logic [ARR_W-1:0] arrival_time;
	logic [RUN_W-1:0] run_time;

	modport source (output valid, cmd, arrival_time, run_time, input ready);
	modport sink (input valid, cmd, arrival_time, run_time, output ready);

endinterface

// ----- hw/rtl/hrrn_result_if.sv -----
interface hrrn_result_if;
	import hrrn_pkg::*;

	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0] process_index;
	logic [TIME_W-1:0] start_time;
	logic [TIME_W-1:0] finish_time;
	logic waited;

	modport source (output valid, status, process_index, start_time, finish_time, waited,
		input ready);
	modport sink (input valid, status, process_index, start_time, finish_time, waited,
		output ready);

endinterface

// ----- hw/rtl/hrrn_process_dispatcher_unit.sv -----
// Highest-response-ratio-next dispatcher with a 32-entry process table held in a
// synchronous RAM (arrival and run time per slot) plus a flip-flop pending mark per
// slot. A load transaction captures the item, then does the table write and result.
// A dispatch transaction reads every slot once; each slot passes through the
// cross-multiplier and then the compare-and-update of the running best, since
// each slot's products use the best found so far. The same pass tracks the
// earliest pending arrival, so when nothing has arrived yet the block jumps time
// to that arrival without a second pass. Ratios are compared exactly; equal
// ratios go to the lowest slot. Finish time and current time saturate at all
// ones. Slots are never reused after a dispatch. A new transaction is taken
// while a previous result still waits in the output register.
module hrrn_process_dispatcher_unit (
	input logic clk,
	input logic arst_n,
	hrrn_item_if.sink item,
	hrrn_result_if.source result
);
	import hrrn_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_READ,
		S_MUL,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;

	// Captured transaction
	logic item_cmd_q;
	logic [ARR_W-1:0] item_arr_q;
	logic [RUN_W-1:0] item_run_q;

	// Block state
	logic [MAX_PROCESSES-1:0] pending_q;
	logic [CNT_W-1:0] count_q;
	logic [TIME_W-1:0] cur_q;

	// Scan registers
	logic [SLOT_W-1:0] idx_q;
	logic any_q;
	logic [ARR_W-1:0] min_arr_q;
	logic [RUN_W-1:0] min_run_q;
	logic [SLOT_W-1:0] min_slot_q;
	logic have_best_q;
	logic [NUM_W-1:0] best_num_q;
	logic [RUN_W-1:0] best_run_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic arrived_q;
	logic [NUM_W-1:0] num_q;
	logic [RUN_W-1:0] run_q;
	logic [PROD_W-1:0] prod_a_q;
	logic [PROD_W-1:0] prod_b_q;

	// Output register
	logic out_valid_q;
	status_t out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [TIME_W-1:0] out_start_q;
	logic [TIME_W-1:0] out_finish_q;
	logic out_waited_q;

	// Process table
	logic [MEM_W-1:0] mem_q [MAX_PROCESSES];
	logic [MEM_W-1:0] rd_data_q;
	logic [SLOT_W-1:0] rd_addr;
	logic mem_we;
	logic [SLOT_W-1:0] load_slot;

	logic out_free;
	logic out_load;
	logic item_fire;
	logic last_slot;
	logic [ARR_W-1:0] rd_arr;
	logic [RUN_W-1:0] rd_run;
	logic slot_pending;
	logic slot_arrived;
	logic [NUM_W-1:0] slot_num;
	logic table_full;

	logic [SLOT_W-1:0] sel_slot;
	logic [TIME_W-1:0] sel_start;
	logic [RUN_W-1:0] sel_run;
	logic sel_waited;
	logic [NUM_W-1:0] finish_sum;
	logic [TIME_W-1:0] finish_sat;

	assign item.ready = (state_q == S_IDLE);
	assign item_fire = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == S_LOAD || state_q == S_DONE) && out_free;

	assign result.valid = out_valid_q;
	assign result.status = out_status_q;
	assign result.process_index = out_idx_q;
	assign result.start_time = out_start_q;
	assign result.finish_time = out_finish_q;
	assign result.waited = out_waited_q;

	// Slot under scan
	assign last_slot = (idx_q == SLOT_W'(MAX_PROCESSES - 1));
	assign rd_arr = rd_data_q[MEM_W-1:RUN_W];
	assign rd_run = rd_data_q[RUN_W-1:0];
	assign slot_pending = pending_q[idx_q];
	assign slot_arrived = slot_pending && (TIME_W'(rd_arr) <= cur_q);
	assign slot_num = NUM_W'(cur_q) - NUM_W'(rd_arr) + NUM_W'(rd_run);

	// Next read: slot 0 when the scan starts, the following slot during compare
	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_READ) begin
			rd_addr = '0;
		end else if (state_q == S_CMP && !last_slot) begin
			rd_addr = idx_q + SLOT_W'(1);
		end
	end

	// Load write
	assign table_full = (count_q >= CNT_W'(MAX_PROCESSES));
	assign load_slot = count_q[SLOT_W-1:0];
	assign mem_we = (state_q == S_LOAD) && out_free && (item_run_q != '0) && !table_full;

	// Dispatch choice: best arrived process, else the earliest arrival after a jump
	always_comb begin
		if (have_best_q) begin
			sel_slot = best_slot_q;
			sel_start = cur_q;
			sel_run = best_run_q;
			sel_waited = 1'b0;
		end else begin
			sel_slot = min_slot_q;
			sel_start = TIME_W'(min_arr_q);
			sel_run = min_run_q;
			sel_waited = 1'b1;
		end
	end

	assign finish_sum = NUM_W'(sel_start) + NUM_W'(sel_run);
	assign finish_sat = finish_sum[NUM_W-1] ? '1 : finish_sum[TIME_W-1:0];

	// Table RAM, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[load_slot] <= {item_arr_q, item_run_q};
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_cmd_q <= CMD_LOAD;
			item_arr_q <= '0;
			item_run_q <= '0;
			pending_q <= '0;
			count_q <= '0;
			cur_q <= '0;
			idx_q <= '0;
			any_q <= 1'b0;
			min_arr_q <= '0;
			min_run_q <= '0;
			min_slot_q <= '0;
			have_best_q <= 1'b0;
			best_num_q <= '0;
			best_run_q <= '0;
			best_slot_q <= '0;
			arrived_q <= 1'b0;
			num_q <= '0;
			run_q <= '0;
			prod_a_q <= '0;
			prod_b_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= STAT_LOADED;
			out_idx_q <= '0;
			out_start_q <= '0;
			out_finish_q <= '0;
			out_waited_q <= 1'b0;
		end else begin
			// Result valid: set on completion, dropped once the sink takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_fire) begin
						item_cmd_q <= item.cmd;
						item_arr_q <= item.arrival_time;
						item_run_q <= item.run_time;
						state_q <= (item.cmd == CMD_DISPATCH) ? S_READ : S_LOAD;
					end
				end

				S_LOAD: begin
					if (out_free) begin
						out_idx_q <= '0;
						out_start_q <= '0;
						out_finish_q <= '0;
						out_waited_q <= 1'b0;
						if (item_run_q == '0) begin
							out_status_q <= STAT_ZERO_RUN;
						end else if (table_full) begin
							out_status_q <= STAT_FULL;
						end else begin
							out_status_q <= STAT_LOADED;
							out_idx_q <= IDX_W'(load_slot);
							pending_q[load_slot] <= 1'b1;
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end

				// Slot 0 read in flight; clear the scan
				S_READ: begin
					idx_q <= '0;
					any_q <= 1'b0;
					have_best_q <= 1'b0;
					state_q <= S_MUL;
				end

				// Cross products against the running best, earliest arrival tracking
				S_MUL: begin
					arrived_q <= slot_arrived;
					num_q <= slot_num;
					run_q <= rd_run;
					prod_a_q <= slot_num * best_run_q;
					prod_b_q <= best_num_q * rd_run;
					if (slot_pending && (!any_q || rd_arr < min_arr_q)) begin
						any_q <= 1'b1;
						min_arr_q <= rd_arr;
						min_run_q <= rd_run;
						min_slot_q <= idx_q;
					end
					state_q <= S_CMP;
				end

				// Strictly higher ratio wins, so ties keep the lower slot
				S_CMP: begin
					if (arrived_q && (!have_best_q || prod_a_q > prod_b_q)) begin
						have_best_q <= 1'b1;
						best_num_q <= num_q;
						best_run_q <= run_q;
						best_slot_q <= idx_q;
					end
					if (last_slot) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
						state_q <= S_MUL;
					end
				end

				S_DONE: begin
					if (out_free) begin
						if (!any_q) begin
							out_status_q <= STAT_EMPTY;
							out_idx_q <= '0;
							out_start_q <= '0;
							out_finish_q <= '0;
							out_waited_q <= 1'b0;
						end else begin
							out_status_q <= STAT_DISPATCHED;
							out_idx_q <= IDX_W'(sel_slot);
							out_start_q <= sel_start;
							out_finish_q <= finish_sat;
							out_waited_q <= sel_waited;
							pending_q[sel_slot] <= 1'b0;
							cur_q <= finish_sat;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result appears only when a load or a dispatch completes
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LOAD || state_q == S_DONE))
	else $error("result raised outside load or dispatch completion");

	// The fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PROCESSES))
	else $error("fill count beyond table size");

	// A dispatched slot was pending when chosen
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && any_q) |-> pending_q[sel_slot])
	else $error("dispatched slot was not pending");

	// Time never runs backward across a dispatch
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (cur_q >= $past(cur_q)))
	else $error("current time decreased");

	// A dispatch scan only runs for a dispatch transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_CMP) |-> (item_cmd_q == CMD_DISPATCH))
	else $error("scan running for a load transaction");

endmodule
